// File: sv/cdsp_pkg.sv
package cdsp_pkg;

    localparam int NODE_COUNT_DEF   = 8;
    localparam int MAX_BRANCHES_DEF = 3;
    localparam int DIST_BITS_DEF    = 8;
    localparam int NODE_BITS        = 3;
    localparam int COST_BITS        = 11;
    localparam logic [COST_BITS-1:0] COST_MAX = 11'd2047;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // saturating cost adder, the path-cost arithmetic of the search
    function automatic logic [COST_BITS-1:0] sat_add(
        input logic [COST_BITS-1:0] a,
        input logic [COST_BITS-1:0] b
    );
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction

endpackage

// File: sv/cdsp_dist_mem.sv
module cdsp_dist_mem #(
    parameter int NODE_COUNT = cdsp_pkg::NODE_COUNT_DEF,
    parameter int DIST_BITS  = cdsp_pkg::DIST_BITS_DEF,
    localparam int IW        = $clog2(NODE_COUNT)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [IW-1:0]        wr_row,
    input  logic [IW-1:0]        wr_col,
    input  logic [DIST_BITS-1:0] wr_data,
    input  logic [IW-1:0]        rd_row,
    input  logic [IW-1:0]        rd_col,
    output logic [DIST_BITS-1:0] rd_data
);
    // full power-of-two rows so {row, col} always lands inside the array
    localparam int DEPTH = 1 << (2 * IW);

    logic [DIST_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    logic                 rd_vld_reg;
    logic [DIST_BITS-1:0] rd_q_reg;

    // valid bit per entry stands in for the cleared matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[{wr_row, wr_col}] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{wr_row, wr_col}] <= wr_data;
        end
        rd_q_reg   <= mem[{rd_row, rd_col}];
        rd_vld_reg <= vld_reg[{rd_row, rd_col}];
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;
endmodule

// File: sv/cdsp_search.sv
module cdsp_search #(
    parameter int NODE_COUNT   = cdsp_pkg::NODE_COUNT_DEF,
    parameter int MAX_BRANCHES = cdsp_pkg::MAX_BRANCHES_DEF,
    parameter int DIST_BITS    = cdsp_pkg::DIST_BITS_DEF,
    localparam int IW          = $clog2(NODE_COUNT),
    localparam int XW          = $clog2(NODE_COUNT + 1),
    localparam int BW          = $clog2(MAX_BRANCHES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              go,
    input  logic [cdsp_pkg::NODE_BITS-1:0]    start_node,
    input  logic [cdsp_pkg::NODE_BITS-1:0]    target_node,
    output logic [IW-1:0]                     rd_row,
    output logic [IW-1:0]                     rd_col,
    input  logic [DIST_BITS-1:0]              rd_data,
    output logic                              done,
    output logic                              best_valid,
    output logic [XW-1:0]                     best_length,
    output logic [cdsp_pkg::COST_BITS-1:0]    best_cost,
    input  logic [XW-1:0]                     out_idx,
    output logic [IW-1:0]                     out_node
);
    localparam int CB = cdsp_pkg::COST_BITS;

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_READ, ST_EVAL, ST_DONE} state_t;

    state_t state_reg;
    logic [IW-1:0] stk_node_reg [NODE_COUNT];
    logic [XW-1:0] stk_nxt_reg  [NODE_COUNT];
    logic [BW-1:0] stk_br_reg   [NODE_COUNT];
    logic [CB-1:0] stk_cost_reg [NODE_COUNT];
    logic [IW-1:0] best_nodes_reg [NODE_COUNT];
    logic [NODE_COUNT-1:0] mask_reg;
    logic [IW-1:0] dep_reg;
    logic [IW-1:0] nb_reg;
    logic          bvalid_reg, bsecond_reg;
    logic [XW-1:0] blen_reg;
    logic [CB-1:0] bcost_reg;
    logic [IW-1:0] tgt_reg;
    logic          tgt_ok_reg;

    logic [IW-1:0] here;
    logic [XW-1:0] nxt;
    logic [CB-1:0] newc;
    logic          take;
    logic          deep_ok;

    assign here    = stk_node_reg[dep_reg];
    assign nxt     = stk_nxt_reg[dep_reg];
    assign rd_row  = here;
    assign rd_col  = nb_reg;
    assign newc    = cdsp_pkg::sat_add(stk_cost_reg[dep_reg],
                                       CB'(rd_data));
    assign deep_ok = ({1'b0, dep_reg} + 1'b1) < (IW+1)'(NODE_COUNT);
    always_comb begin
        if (!bvalid_reg)      take = 1'b1;
        else if (bsecond_reg) take = newc <= bcost_reg;
        else                  take = newc < bcost_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            bvalid_reg  <= 1'b0;
            bsecond_reg <= 1'b0;
            blen_reg    <= '0;
            bcost_reg   <= '0;
            dep_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (go) begin
                        bsecond_reg <= 1'b0;
                        bcost_reg   <= '0;
                        dep_reg     <= '0;
                        tgt_reg     <= IW'(target_node);
                        tgt_ok_reg  <= 32'(target_node) < NODE_COUNT;
                        if (32'(start_node) >= NODE_COUNT) begin
                            bvalid_reg <= 1'b0;
                            blen_reg   <= '0;
                            mask_reg   <= '0;
                            state_reg  <= ST_DONE;
                        end else if (start_node == target_node) begin
                            bvalid_reg        <= 1'b1;
                            blen_reg          <= XW'(1);
                            best_nodes_reg[0] <= IW'(start_node);
                            mask_reg          <= '0;
                            state_reg         <= ST_DONE;
                        end else begin
                            bvalid_reg      <= 1'b0;
                            blen_reg        <= '0;
                            stk_node_reg[0] <= IW'(start_node);
                            stk_cost_reg[0] <= '0;
                            stk_nxt_reg[0]  <= '0;
                            stk_br_reg[0]   <= '0;
                            mask_reg        <= NODE_COUNT'(1) << start_node;
                            state_reg       <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // find next candidate at this level, or pop (finish at the root)
                    if (nxt >= XW'(NODE_COUNT) ||
                        stk_br_reg[dep_reg] >= BW'(MAX_BRANCHES)) begin
                        if (dep_reg == '0) begin
                            mask_reg  <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            mask_reg[here] <= 1'b0;
                            dep_reg        <= dep_reg - 1'b1;
                        end
                    end else begin
                        stk_nxt_reg[dep_reg] <= nxt + 1'b1;
                        if (!mask_reg[nxt[IW-1:0]]) begin
                            nb_reg    <= nxt[IW-1:0];
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: state_reg <= ST_EVAL;
                ST_EVAL: begin
                    state_reg <= ST_SCAN;
                    if (rd_data != '0) begin
                        stk_br_reg[dep_reg] <= stk_br_reg[dep_reg] + 1'b1;
                        if (deep_ok) begin
                            stk_node_reg[dep_reg+1'b1] <= nb_reg;
                            stk_cost_reg[dep_reg+1'b1] <= newc;
                            stk_nxt_reg[dep_reg+1'b1]  <= '0;
                            stk_br_reg[dep_reg+1'b1]   <= '0;
                            if (tgt_ok_reg && nb_reg == tgt_reg) begin
                                if (take) begin
                                    for (int k = 0; k < NODE_COUNT; k++) begin
                                        if (k <= int'(dep_reg)) begin
                                            best_nodes_reg[k] <= stk_node_reg[k];
                                        end
                                    end
                                    best_nodes_reg[dep_reg+1'b1] <= nb_reg;
                                    blen_reg    <= XW'(dep_reg) + XW'(2);
                                    bcost_reg   <= newc;
                                    bsecond_reg <= bvalid_reg ? !bsecond_reg : 1'b0;
                                    bvalid_reg  <= 1'b1;
                                end
                            end else begin
                                mask_reg[nb_reg] <= 1'b1;
                                dep_reg          <= dep_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done        = state_reg == ST_DONE;
    assign best_valid  = bvalid_reg;
    assign best_length = blen_reg;
    assign best_cost   = bcost_reg;
    assign out_node    = best_nodes_reg[out_idx[IW-1:0]];
endmodule

// File: sv/capped_dfs_shortest_path_top.sv
// channel | ports                                            | direction
// s_      | s_valid s_ready action from/to distance start    | in, one word per item
// m_      | m_valid m_ready path_node path_cost found last   | out, one word per node
// cfg     | cfg_wr_en cfg_wr_data                            | in, target node
//
// an edge write is taken on acceptance and s_ready stays high, so writes go back to back
// a search: per neighbor index only a scan step if it is already on the path, the scan, read
// and eval steps if its distance is read, a scan step per pop, then the ST_DONE and T_EMIT states
// before the first result word; all set by the single sequencer over the distance memory's read port;
// result words come straight from the held keeper, one per cycle while m_ready is high
// reset (aresetn, synchronous) clears matrix valid bits, target, keeper valid/length/cost and control
// s_ready is low from a search's acceptance until its last result word is taken
module capped_dfs_shortest_path_top #(
    parameter int NODE_COUNT   = cdsp_pkg::NODE_COUNT_DEF,
    parameter int MAX_BRANCHES = cdsp_pkg::MAX_BRANCHES_DEF,
    parameter int DIST_BITS    = cdsp_pkg::DIST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cdsp_pkg::NODE_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [cdsp_pkg::NODE_BITS-1:0] s_from_node,
    input  logic [cdsp_pkg::NODE_BITS-1:0] s_to_node,
    input  logic [DIST_BITS-1:0]           s_distance,
    input  logic [cdsp_pkg::NODE_BITS-1:0] s_start_node,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cdsp_pkg::NODE_BITS-1:0] m_path_node,
    output logic [cdsp_pkg::COST_BITS-1:0] m_path_cost,
    output logic                           m_found,
    output logic                           m_last
);
    localparam int IW = $clog2(NODE_COUNT);
    localparam int XW = $clog2(NODE_COUNT + 1);

    typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_EMIT} state_t;

    state_t state_reg;
    logic [cdsp_pkg::NODE_BITS-1:0] target_reg;
    logic [XW-1:0] idx_reg;
    logic          accept, wr_go, srch_go, wr_ok;
    logic [IW-1:0] s_rd_row, s_rd_col, rd_row, rd_col;
    logic [DIST_BITS-1:0] rd_data;
    logic          done, bvalid;
    logic [XW-1:0] blen;
    logic [cdsp_pkg::COST_BITS-1:0] bcost;
    logic [IW-1:0] onode;

    assign s_ready = state_reg == T_IDLE;
    assign accept  = s_valid && s_ready;
    // out-of-range node indexes drop the write
    assign wr_ok   = 32'(s_from_node) < NODE_COUNT && 32'(s_to_node) < NODE_COUNT;
    assign wr_go   = accept && s_action == cdsp_pkg::ACT_WRITE && wr_ok;
    assign srch_go = accept && s_action == cdsp_pkg::ACT_SEARCH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    cdsp_dist_mem #(.NODE_COUNT(NODE_COUNT), .DIST_BITS(DIST_BITS)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_go),
        .wr_row  (IW'(s_from_node)),
        .wr_col  (IW'(s_to_node)),
        .wr_data (s_distance),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );
    assign rd_row = s_rd_row;
    assign rd_col = s_rd_col;

    cdsp_search #(
        .NODE_COUNT(NODE_COUNT), .MAX_BRANCHES(MAX_BRANCHES), .DIST_BITS(DIST_BITS)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (srch_go),
        .start_node  (s_start_node),
        .target_node (target_reg),
        .rd_row      (s_rd_row),
        .rd_col      (s_rd_col),
        .rd_data     (rd_data),
        .done        (done),
        .best_valid  (bvalid),
        .best_length (blen),
        .best_cost   (bcost),
        .out_idx     (idx_reg),
        .out_node    (onode)
    );

    // result words are read straight from the held keeper
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                T_IDLE: if (srch_go) state_reg <= T_SEARCH;
                T_SEARCH: begin
                    if (done) begin
                        idx_reg   <= '0;
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (m_ready) begin
                        if (m_last) state_reg <= T_IDLE;
                        else        idx_reg   <= idx_reg + 1'b1;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid      = state_reg == T_EMIT;
    assign m_found      = bvalid;
    assign m_path_node  = bvalid ? cdsp_pkg::NODE_BITS'(onode) : '0;
    assign m_path_cost  = bvalid ? bcost : '0;
    assign m_last       = !bvalid || (idx_reg + 1'b1 == blen);
endmodule

// File: sv/cdsp_checker.sv
module cdsp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_found,
    input logic       m_last,
    input logic [10:0] m_path_cost,
    input logic [2:0] m_path_node
);
    // no input taken while results are pending
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while emitting");
    // a not-found word is the single last word
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_last && m_path_cost == 11'd0
                                   && m_path_node == 3'd0))
        else $error("bad not-found word");
    // cost is fixed across one search's words
    a_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && $stable(m_path_cost)))
        else $error("cost changed");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_path_node)))
        else $error("stalled word changed");
endmodule

bind capped_dfs_shortest_path_top cdsp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found), .m_last(m_last),
    .m_path_cost(m_path_cost), .m_path_node(m_path_node)
);

// File: tb/capped_dfs_shortest_path_top_tb.sv
`timescale 1ns / 1ps

module capped_dfs_shortest_path_top_tb;

    localparam int NODES    = 8;
    localparam int BRANCHES = 3;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 40;

    // one word of the path stream
    typedef struct packed {
        logic [cdsp_pkg::NODE_BITS-1:0] node;
        logic [cdsp_pkg::COST_BITS-1:0] cost;
        logic                           found;
        logic                           last;
    } path_word_t;

    // one row of the directed table
    typedef struct {
        logic                 action;
        logic [2:0]           from_n;
        logic [2:0]           to_n;
        logic [7:0]           len;
        logic [2:0]           start;
        int                   n_known;   // 0 means use the path solver
        path_word_t           known[2];
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [cdsp_pkg::NODE_BITS-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = cdsp_pkg::ACT_WRITE;
    logic [cdsp_pkg::NODE_BITS-1:0] s_from_node = '0;
    logic [cdsp_pkg::NODE_BITS-1:0] s_to_node = '0;
    logic [7:0] s_distance = '0;
    logic [cdsp_pkg::NODE_BITS-1:0] s_start_node = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [cdsp_pkg::NODE_BITS-1:0] m_path_node;
    logic [cdsp_pkg::COST_BITS-1:0] m_path_cost;
    logic m_found;
    logic m_last;

    capped_dfs_shortest_path_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_from_node(s_from_node), .s_to_node(s_to_node),
        .s_distance(s_distance), .s_start_node(s_start_node),
        .m_valid(m_valid), .m_ready(m_ready), .m_path_node(m_path_node),
        .m_path_cost(m_path_cost), .m_found(m_found), .m_last(m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // shadow copy of the block state
    logic [7:0] edge_len [NODES][NODES];
    logic [2:0] goal_node;
    path_word_t pending_words[$];
    int errors;
    int cycles;

    // solver scratch
    logic [2:0]  walk_node [NODES];
    logic [10:0] walk_cost [NODES];
    logic [2:0]  keep_nodes [NODES];
    int          keep_len;
    logic [10:0] keep_cost;
    logic        keep_ok;
    logic        keep_second;

    function automatic void offer_route(input int depth, input logic [10:0] c);
        logic take;
        if (!keep_ok) begin
            take = 1'b1;
        end else if (keep_second) begin
            take = (c <= keep_cost);
        end else begin
            take = (c < keep_cost);
        end
        if (take) begin
            for (int k = 0; k <= depth; k++) keep_nodes[k] = walk_node[k];
            keep_len = depth + 1;
            keep_cost = c;
            keep_second = keep_ok ? !keep_second : 1'b0;
            keep_ok = 1'b1;
        end
    endfunction

    // recursive walk: neighbors in index order, first BRANCHES eligible ones only
    function automatic void explore(input int depth, input logic [7:0] visited);
        int taken;
        logic [11:0] sum;
        logic [2:0] here;
        taken = 0;
        here = walk_node[depth];
        for (int nb = 0; nb < NODES && taken < BRANCHES; nb++) begin
            if (!visited[nb] && edge_len[here][nb] != 0) begin
                taken++;
                sum = {1'b0, walk_cost[depth]} + edge_len[here][nb];
                walk_node[depth+1] = nb[2:0];
                walk_cost[depth+1] = sum[11] ? cdsp_pkg::COST_MAX : sum[10:0];
                if (nb == goal_node) begin
                    offer_route(depth + 1, walk_cost[depth+1]);
                end else begin
                    explore(depth + 1, visited | (8'b1 << nb));
                end
            end
        end
    endfunction

    // queue the words a search is expected to give
    function automatic void solve_route(input logic [2:0] start);
        path_word_t w;
        keep_ok = 1'b0;
        keep_second = 1'b0;
        keep_len = 0;
        keep_cost = '0;
        walk_node[0] = start;
        walk_cost[0] = '0;
        if (start == goal_node) offer_route(0, '0);
        else explore(0, 8'b1 << start);
        if (!keep_ok) begin
            w = '{node: '0, cost: '0, found: 1'b0, last: 1'b1};
            pending_words.push_back(w);
        end else begin
            for (int k = 0; k < keep_len; k++) begin
                w = '{node: keep_nodes[k], cost: keep_cost, found: 1'b1,
                      last: (k == keep_len - 1)};
                pending_words.push_back(w);
            end
        end
    endfunction

    // result side: random stalls, check against the oldest expectation
    initial begin
        path_word_t want;
        errors = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word node=%0d", m_path_node);
                    errors++;
                end else begin
                    want = pending_words.pop_front();
                    if (m_path_node !== want.node) begin
                        $error("path_node exp %0d got %0d", want.node, m_path_node);
                        errors++;
                    end
                    if (m_path_cost !== want.cost) begin
                        $error("path_cost exp %0d got %0d", want.cost, m_path_cost);
                        errors++;
                    end
                    if (m_found !== want.found) begin
                        $error("found exp %0d got %0d", want.found, m_found);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, m_last);
                        errors++;
                    end
                end
            end
            @(negedge aclk);
            // mostly ready, sometimes short stalls, rarely long ones
            if ($urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // timeout watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // present one word, hold it until accepted, update the shadow state
    task automatic send_word(input logic act, input logic [2:0] fn, input logic [2:0] tn,
                             input logic [7:0] d, input logic [2:0] st);
        @(negedge aclk);
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end else if ($urandom_range(0, 99) < 3) begin
            repeat ($urandom_range(15, 50)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_from_node <= fn;
        s_to_node <= tn;
        s_distance <= d;
        s_start_node <= st;
        do @(posedge aclk); while (!s_ready);
        if (act == cdsp_pkg::ACT_WRITE) edge_len[fn][tn] = d;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // run with the expected words from the solver
    task automatic push_item(input logic act, input logic [2:0] fn, input logic [2:0] tn,
                             input logic [7:0] d, input logic [2:0] st);
        if (act == cdsp_pkg::ACT_SEARCH) solve_route(st);
        send_word(act, fn, tn, d, st);
    endtask

    // write the target only once the block has gone quiet
    task automatic set_goal(input logic [2:0] g);
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= g;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        goal_node = g;
    endtask

    task automatic clear_graph();
        for (int a = 0; a < NODES; a++)
            for (int b = 0; b < NODES; b++)
                if (edge_len[a][b] != 0)
                    push_item(cdsp_pkg::ACT_WRITE, 3'(a), 3'(b), 8'd0, '0);
    endtask

    dir_row_t dir_rows[$];
    path_word_t w0, w1;

    initial begin
        for (int a = 0; a < NODES; a++)
            for (int b = 0; b < NODES; b++) edge_len[a][b] = '0;
        goal_node = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, target 0 after reset
        w0 = '{node: 3'd0, cost: 11'd0, found: 1'b0, last: 1'b1};
        w1 = '{node: 3'd0, cost: 11'd0, found: 1'b1, last: 1'b1};
        // empty graph: nothing reachable
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd7, 3'd7, 8'hff, 3'd5, 1,
                             '{w0, w0}});
        // start equals target: one-node path, cost zero
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd0, 1,
                             '{w1, w0}});
        // direct edge 7 -> 0 at full length
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd7, 3'd0, 8'd255, 3'd7, 0,
                             '{w0, w0}});
        w1 = '{node: 3'd7, cost: 11'd255, found: 1'b1, last: 1'b0};
        w0 = '{node: 3'd0, cost: 11'd255, found: 1'b1, last: 1'b1};
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd7, 2,
                             '{w1, w0}});
        // long chain 1..7 -> 0 with big weights, the largest reachable cost
        for (int k = 1; k < 7; k++)
            dir_rows.push_back('{cdsp_pkg::ACT_WRITE, k[2:0], k[2:0] + 3'd1, 8'd255,
                                 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd1, 0,
                             '{w0, w0}});
        // equal-cost ties through parallel routes 2->3->0 vs 2->7->0
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd2, 3'd7, 8'd1, 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd3, 3'd0, 8'd1, 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd2, 3'd3, 8'd255, 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd2, 3'd0, 8'd1, 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_WRITE, 3'd2, 3'd1, 8'd1, 3'd0, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd2, 0, '{w0, w0}});
        dir_rows.push_back('{cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd3, 0, '{w0, w0}});

        foreach (dir_rows[i]) begin
            if (dir_rows[i].n_known != 0 && dir_rows[i].action == cdsp_pkg::ACT_SEARCH) begin
                for (int k = 0; k < dir_rows[i].n_known; k++)
                    pending_words.push_back(dir_rows[i].known[k]);
                send_word(dir_rows[i].action, dir_rows[i].from_n, dir_rows[i].to_n,
                          dir_rows[i].len, dir_rows[i].start);
            end else begin
                push_item(dir_rows[i].action, dir_rows[i].from_n, dir_rows[i].to_n,
                          dir_rows[i].len, dir_rows[i].start);
            end
        end

        // other extreme for the target
        set_goal(3'd7);
        push_item(cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd1);
        push_item(cdsp_pkg::ACT_SEARCH, 3'd0, 3'd0, 8'd0, 3'd7);

        // random phases: fresh graph per phase, mostly writes mixed with searches
        for (int ph = 0; ph < 8; ph++) begin
            set_goal(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom_range(0, 7)));
            clear_graph();
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(0, 99) < 65) begin
                    // small weights make ties; a few large ones
                    push_item(cdsp_pkg::ACT_WRITE, 3'($urandom), 3'($urandom),
                              ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                              8'($urandom_range(0, 4)), 3'($urandom));
                end else begin
                    push_item(cdsp_pkg::ACT_SEARCH, 3'($urandom), 3'($urandom),
                              8'($urandom), 3'($urandom));
                end
            end
        end

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
